// ----- sv/leb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leb_pkg
// Shared format codes, sizes and inter-stage types of the LEB128 serializer.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int VALUE_W  = 64;
    localparam int OP_W     = 3;
    localparam int MAX_BYTES = 10;
    localparam int CNT_W    = 4;
    localparam int GROUP_W  = 7;

    localparam logic [OP_W-1:0] OP_BYTE = 3'd0;
    localparam logic [OP_W-1:0] OP_ULEB = 3'd1;
    localparam logic [OP_W-1:0] OP_SLEB = 3'd2;
    localparam logic [OP_W-1:0] OP_LE32 = 3'd3;
    localparam logic [OP_W-1:0] OP_LE64 = 3'd4;

    // scan stage result: which byte positions may end the encoding
    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic                 is_le;     // 8-bit byte layout, no continuation bits
        logic                 is_sleb;   // groups past bit 63 repeat the sign
        logic [MAX_BYTES-1:0] last_sel;  // first set bit marks the final byte
    } t_scan;

    // packed stage result: bytes in stream order, byte 0 in the low bits
    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;
        logic [CNT_W-1:0]       last_idx;
    } t_pack;

endpackage
`default_nettype wire

// ----- sv/leb_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leb_scan
// Stage 2: decodes the format and finds the candidate final byte of each
// encoding. Items with an undefined format are dropped here.
// ----------------------------------------------------------------------------
module leb_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [leb_pkg::VALUE_W-1:0]   i_value,
    input  wire logic [leb_pkg::OP_W-1:0]      i_op,
    output logic                               o_ready,
    output logic                               o_valid,
    output leb_pkg::t_scan                     o_scan,
    input  wire logic                          i_ready
);
    import leb_pkg::*;

    logic                 r_valid;
    t_scan                r_scan;
    t_scan                n_scan;
    logic                 n_ok;
    logic [MAX_BYTES-1:0] ufl;
    logic [MAX_BYTES-1:0] sfl;

    // unsigned: nothing left above the group; signed: all bits from the
    // group's sign bit upward agree
    always_comb begin
        for (int k = 0; k < MAX_BYTES - 1; k++) begin
            ufl[k] = (i_value >> (GROUP_W * (k + 1))) == '0;
            sfl[k] = ((i_value >> (GROUP_W * k + GROUP_W - 1)) == '0) ||
                     ((~i_value >> (GROUP_W * k + GROUP_W - 1)) == '0);
        end
        ufl[MAX_BYTES-1] = 1'b1;
        sfl[MAX_BYTES-1] = 1'b1;
    end

    always_comb begin
        n_scan.value    = i_value;
        n_scan.is_le    = 1'b1;
        n_scan.is_sleb  = 1'b0;
        n_scan.last_sel = '0;
        n_ok            = 1'b1;
        case (i_op)
            OP_BYTE: n_scan.last_sel[0] = 1'b1;
            OP_ULEB: begin
                n_scan.is_le    = 1'b0;
                n_scan.last_sel = ufl;
            end
            OP_SLEB: begin
                n_scan.is_le    = 1'b0;
                n_scan.is_sleb  = 1'b1;
                n_scan.last_sel = sfl;
            end
            OP_LE32: n_scan.last_sel[3] = 1'b1;
            OP_LE64: n_scan.last_sel[7] = 1'b1;
            default: n_ok = 1'b0;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_scan <= n_scan;
        end
    end

    assign o_valid = r_valid;
    assign o_scan  = r_scan;

endmodule
`default_nettype wire

// ----- sv/leb_pack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leb_pack
// Stage 3: resolves the final byte index and lays out all output bytes,
// with continuation bits for the LEB128 formats.
// ----------------------------------------------------------------------------
module leb_pack (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire leb_pkg::t_scan  i_scan,
    output logic                 o_ready,
    output logic                 o_valid,
    output leb_pkg::t_pack       o_pack,
    input  wire logic            i_ready
);
    import leb_pkg::*;

    localparam int LE_EXT_W  = 8 * MAX_BYTES;
    localparam int LEB_EXT_W = GROUP_W * MAX_BYTES;

    logic                 r_valid;
    t_pack                r_pack;
    t_pack                n_pack;
    logic [MAX_BYTES-1:0] cont;
    logic                 seen;
    logic [LE_EXT_W-1:0]  le_ext;
    logic [LEB_EXT_W-1:0] leb_ext;

    assign le_ext  = {{(LE_EXT_W - VALUE_W){1'b0}}, i_scan.value};
    assign leb_ext = {{(LEB_EXT_W - VALUE_W){i_scan.is_sleb & i_scan.value[VALUE_W-1]}},
                      i_scan.value};

    always_comb begin
        seen = 1'b0;
        for (int k = 0; k < MAX_BYTES; k++) begin
            seen    = seen | i_scan.last_sel[k];
            cont[k] = !seen;
        end
        n_pack.last_idx = '0;
        for (int k = MAX_BYTES - 1; k >= 0; k--) begin
            if (i_scan.last_sel[k]) begin
                n_pack.last_idx = CNT_W'(k);
            end
        end
        for (int k = 0; k < MAX_BYTES; k++) begin
            if (i_scan.is_le) begin
                n_pack.bytes[8*k +: 8] = le_ext[8*k +: 8];
            end else begin
                n_pack.bytes[8*k +: 8] = {cont[k], leb_ext[GROUP_W*k +: GROUP_W]};
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pack <= n_pack;
        end
    end

    assign o_valid = r_valid;
    assign o_pack  = r_pack;

endmodule
`default_nettype wire

// ----- sv/leb_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leb_emit
// Byte shifter and output register: sends one byte of the held item per
// transfer and takes the next item as its final byte moves out.
// ----------------------------------------------------------------------------
module leb_emit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire leb_pkg::t_pack  i_pack,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [7:0]           o_byte,
    output logic                 o_last,
    input  wire logic            i_stall
);
    import leb_pkg::*;

    logic                      r_busy;
    logic [8*MAX_BYTES-1:0]    r_buf;
    logic [CNT_W-1:0]          r_rem;
    logic                      r_ovalid;
    logic [7:0]                r_obyte;
    logic                      r_olast;
    logic                      out_load;
    logic                      take;

    assign out_load = !r_ovalid || !i_stall;
    assign o_ready  = !r_busy || (out_load && r_rem == '0);
    assign take     = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= r_busy;
            end
            if (take) begin
                r_busy <= 1'b1;
            end else if (r_busy && out_load && r_rem == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_busy) begin
            r_obyte <= r_buf[7:0];
            r_olast <= r_rem == '0;
        end
        if (take) begin
            r_buf <= i_pack.bytes;
            r_rem <= i_pack.last_idx;
        end else if (out_load && r_busy) begin
            r_buf <= {8'h00, r_buf[8*MAX_BYTES-1:8]};
            r_rem <= r_rem - CNT_W'(1);
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

endmodule
`default_nettype wire

// ----- sv/leb128_byte_serializer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leb128_byte_serializer
// Encodes a 64-bit value as a raw byte, unsigned or signed LEB128, or a
// little-endian 32/64-bit word, and streams the bytes out one per transfer.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_item_value and i_operation. An item
// is taken on a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_out_byte and o_last; o_last marks
// the final byte of each item. Undefined format codes produce no bytes.
// Pipeline: input register, format scan, byte packing, then the byte shifter
// with its output register. While i_stall is low the shifter sends one byte
// per cycle, so an item of 1 to 10 bytes holds it until its final byte moves
// out; a waiting next item follows without a gap. Items queue in the three
// stages ahead of the shifter, and o_stall rises when they are all full and
// the shifter cannot take an item.
// When i_stall is high with o_valid high, the output holds its byte and the
// shifter holds; the stages ahead fill up, and nothing is lost or repeated.
// Synchronous reset (i_rst_n low) empties every stage and the output.
// ----------------------------------------------------------------------------
module leb128_byte_serializer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [leb_pkg::VALUE_W-1:0] i_item_value,
    input  wire logic [leb_pkg::OP_W-1:0]    i_operation,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [7:0]                       o_out_byte,
    output logic                             o_last
);
    import leb_pkg::*;

    logic                 r_valid;
    logic [VALUE_W-1:0]   r_value;
    logic [OP_W-1:0]      r_op;
    logic                 in_ready;
    logic                 scan_ready;
    logic                 scan_valid;
    t_scan                scan;
    logic                 pack_ready;
    logic                 pack_valid;
    t_pack                pack;
    logic                 emit_ready;

    assign in_ready = !r_valid || scan_ready;
    assign o_stall  = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_value <= i_item_value;
            r_op    <= i_operation;
        end
    end

    leb_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid),
        .i_value (r_value),
        .i_op    (r_op),
        .o_ready (scan_ready),
        .o_valid (scan_valid),
        .o_scan  (scan),
        .i_ready (pack_ready)
    );

    leb_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (scan_valid),
        .i_scan  (scan),
        .o_ready (pack_ready),
        .o_valid (pack_valid),
        .o_pack  (pack),
        .i_ready (emit_ready)
    );

    leb_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pack_valid),
        .i_pack  (pack),
        .o_ready (emit_ready),
        .o_valid (o_valid),
        .o_byte  (o_out_byte),
        .o_last  (o_last),
        .i_stall (i_stall)
    );

endmodule
`default_nettype wire
